### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold in the same cycle.
`define CSTR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Consequent that must hold in the cycle after the antecedent.
`define CSTR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CSTR_ASSERT(lbl, prop, msg)
`define CSTR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/cstr_pkg.sv
// ----------------------------------------------------------------------------
// Comment stripper package
// Payload types, lexer modes and character constants shared by the block.
// ----------------------------------------------------------------------------
package cstr_pkg;

    localparam int LINE_BITS   = 24;
    localparam int COLUMN_BITS = 16;

    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;

    typedef enum logic [3:0] {
        MODE_PLAIN      = 4'd0,
        MODE_SQ         = 4'd1,
        MODE_DQ         = 4'd2,
        MODE_SQ_ESC     = 4'd3,
        MODE_DQ_ESC     = 4'd4,
        MODE_SLASH      = 4'd5,
        MODE_LINE_COM   = 4'd6,
        MODE_BLOCK_COM  = 4'd7,
        MODE_BLOCK_STAR = 4'd8
    } t_mode;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_in;

    typedef struct packed {
        logic [7:0]             out_byte;
        logic                   out_last;
        logic [LINE_BITS-1:0]   line_number;
        logic [COLUMN_BITS-1:0] column_number;
    } t_out;

    // Results of one lexer step: up to two bytes and the position after it.
    typedef struct packed {
        logic [1:0]             count;
        logic [7:0]             byte0;
        logic [7:0]             byte1;
        logic [LINE_BITS-1:0]   line_number;
        logic [COLUMN_BITS-1:0] column_number;
    } t_step;

endpackage

### rtl/cstr_lexer.sv
// ----------------------------------------------------------------------------
// Comment stripper lexer
// Mode register and position counters; produces the results of one item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cstr_lexer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  cstr_pkg::t_in  i_item,
    output cstr_pkg::t_step o_step
);

    cstr_pkg::t_mode                  r_mode, n_mode;
    logic [cstr_pkg::LINE_BITS-1:0]   r_line, n_line;
    logic [cstr_pkg::COLUMN_BITS-1:0] r_col, n_col;

    logic [7:0] b;
    logic       eoi;

    assign b   = i_item.in_byte;
    assign eoi = i_item.end_of_input;

    // Next mode.
    always_comb begin
        n_mode = r_mode;
        if (i_accept) begin
            if (eoi) begin
                n_mode = cstr_pkg::MODE_PLAIN;
            end else begin
                unique case (r_mode)
                    cstr_pkg::MODE_SQ: begin
                        if (b == cstr_pkg::CH_BSL)     n_mode = cstr_pkg::MODE_SQ_ESC;
                        else if (b == cstr_pkg::CH_SQ) n_mode = cstr_pkg::MODE_PLAIN;
                    end
                    cstr_pkg::MODE_DQ: begin
                        if (b == cstr_pkg::CH_BSL)     n_mode = cstr_pkg::MODE_DQ_ESC;
                        else if (b == cstr_pkg::CH_DQ) n_mode = cstr_pkg::MODE_PLAIN;
                    end
                    cstr_pkg::MODE_SQ_ESC: n_mode = cstr_pkg::MODE_SQ;
                    cstr_pkg::MODE_DQ_ESC: n_mode = cstr_pkg::MODE_DQ;
                    cstr_pkg::MODE_LINE_COM: begin
                        if (b == cstr_pkg::CH_NL) n_mode = cstr_pkg::MODE_PLAIN;
                    end
                    cstr_pkg::MODE_BLOCK_COM: begin
                        if (b == cstr_pkg::CH_STAR) n_mode = cstr_pkg::MODE_BLOCK_STAR;
                    end
                    cstr_pkg::MODE_BLOCK_STAR: begin
                        if (b == cstr_pkg::CH_SLASH)     n_mode = cstr_pkg::MODE_PLAIN;
                        else if (b != cstr_pkg::CH_STAR) n_mode = cstr_pkg::MODE_BLOCK_COM;
                    end
                    cstr_pkg::MODE_SLASH: begin
                        if (b == cstr_pkg::CH_SLASH)     n_mode = cstr_pkg::MODE_LINE_COM;
                        else if (b == cstr_pkg::CH_STAR) n_mode = cstr_pkg::MODE_BLOCK_COM;
                        else if (b == cstr_pkg::CH_SQ)   n_mode = cstr_pkg::MODE_SQ;
                        else if (b == cstr_pkg::CH_DQ)   n_mode = cstr_pkg::MODE_DQ;
                        else                             n_mode = cstr_pkg::MODE_PLAIN;
                    end
                    default: begin
                        if (b == cstr_pkg::CH_SLASH)   n_mode = cstr_pkg::MODE_SLASH;
                        else if (b == cstr_pkg::CH_SQ) n_mode = cstr_pkg::MODE_SQ;
                        else if (b == cstr_pkg::CH_DQ) n_mode = cstr_pkg::MODE_DQ;
                        else                           n_mode = cstr_pkg::MODE_PLAIN;
                    end
                endcase
            end
        end
    end

    // Position counters, saturating.
    always_comb begin
        n_line = r_line;
        n_col  = r_col;
        if (i_accept && !eoi) begin
            if (b == cstr_pkg::CH_NL) begin
                if (r_line != '1) n_line = r_line + 1'b1;
                n_col = {{(cstr_pkg::COLUMN_BITS-1){1'b0}}, 1'b1};
            end else if (r_col != '1) begin
                n_col = r_col + 1'b1;
            end
        end
    end

    // Emitted bytes.
    always_comb begin
        o_step               = '0;
        o_step.byte0         = b;
        o_step.byte1         = b;
        o_step.line_number   = n_line;
        o_step.column_number = n_col;
        if (eoi) begin
            unique case (r_mode)
                cstr_pkg::MODE_SLASH: begin
                    o_step.count = 2'd1;
                    o_step.byte0 = cstr_pkg::CH_SLASH;
                end
                cstr_pkg::MODE_LINE_COM, cstr_pkg::MODE_BLOCK_COM,
                cstr_pkg::MODE_BLOCK_STAR: begin
                    o_step.count = 2'd1;
                    o_step.byte0 = cstr_pkg::CH_SP;
                end
                default: o_step.count = 2'd0;
            endcase
        end else begin
            unique case (r_mode)
                cstr_pkg::MODE_SQ, cstr_pkg::MODE_DQ, cstr_pkg::MODE_SQ_ESC,
                cstr_pkg::MODE_DQ_ESC: o_step.count = 2'd1;
                cstr_pkg::MODE_SLASH: begin
                    // A slash that does not open a comment goes out ahead of the byte.
                    if (b != cstr_pkg::CH_SLASH && b != cstr_pkg::CH_STAR) begin
                        o_step.count = 2'd2;
                        o_step.byte0 = cstr_pkg::CH_SLASH;
                    end
                end
                cstr_pkg::MODE_LINE_COM: begin
                    if (b == cstr_pkg::CH_NL) begin
                        o_step.count = 2'd1;
                        o_step.byte0 = cstr_pkg::CH_SP;
                    end
                end
                cstr_pkg::MODE_BLOCK_COM: o_step.count = 2'd0;
                cstr_pkg::MODE_BLOCK_STAR: begin
                    if (b == cstr_pkg::CH_SLASH) begin
                        o_step.count = 2'd1;
                        o_step.byte0 = cstr_pkg::CH_SP;
                    end
                end
                default: begin
                    if (b != cstr_pkg::CH_SLASH) o_step.count = 2'd1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= cstr_pkg::MODE_PLAIN;
            r_line <= {{(cstr_pkg::LINE_BITS-1){1'b0}}, 1'b1};
            r_col  <= {{(cstr_pkg::COLUMN_BITS-1){1'b0}}, 1'b1};
        end else begin
            r_mode <= n_mode;
            r_line <= n_line;
            r_col  <= n_col;
        end
    end

    `CSTR_ASSERT_NEXT(a_eoi_plain, i_accept && eoi, r_mode == cstr_pkg::MODE_PLAIN, "mode not plain after end of input")
    `CSTR_ASSERT(a_pos_nonzero, (r_line != '0) && (r_col != '0), "position counter reached zero")
    `CSTR_ASSERT_NEXT(a_eoi_keeps_pos, i_accept && eoi, $stable(r_line) && $stable(r_col), "end of input moved the position")

endmodule

### rtl/comment_stripper_unit.sv
// ----------------------------------------------------------------------------
// Comment stripper unit
// Replaces C-style line and block comments with a single space, honouring
// quoted text and backslash escapes, and reports the position of each byte.
// ----------------------------------------------------------------------------
// Usage: source bytes arrive on the input channel, one per transfer, with
// end_of_input set on a flush transfer that carries no byte. Each transfer
// yields zero, one or two result transfers on the output channel; the last
// result of a transfer carries out_last, and all results of it carry the line
// and column of the next byte to be read.
// Results are registered in the result queue before they reach the output.
// Throughput: one input transfer per cycle while the receiver does not stall
// and each yields at most one result; a two-result transfer leaves an extra
// result, which the four-entry queue absorbs until it holds three entries.
// Reset: the lexer returns to plain text, line and column return to 1 and the
// queue empties. Reset is synchronous and active low.
// Stall: when the receiver stalls, results wait in the queue and the input is
// stalled once fewer than two free entries remain.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module comment_stripper_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  cstr_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output cstr_pkg::t_out o_out_data
);

    cstr_pkg::t_step step;
    logic            in_xfer;
    logic            out_xfer;

    // Result queue: four entries, two may be written and one read per cycle.
    cstr_pkg::t_out r_mem [4];
    logic [1:0]     r_wr_ptr, n_wr_ptr;
    logic [1:0]     r_rd_ptr, n_rd_ptr;
    logic [2:0]     r_count, n_count;
    logic [1:0]     wr_cnt;
    cstr_pkg::t_out entry0, entry1;

    // Room for the worst case of two results is required to take a transfer.
    assign o_in_stall = (r_count > 3'd2);
    assign in_xfer    = i_in_valid && !o_in_stall;

    assign o_out_valid = (r_count != 3'd0);
    assign o_out_data  = r_mem[r_rd_ptr];
    assign out_xfer    = o_out_valid && !i_out_stall;

    cstr_lexer u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(in_xfer),
        .i_item  (i_in_data),
        .o_step  (step)
    );

    // The first entry is the last result only when a single byte is emitted.
    always_comb begin
        entry0.out_byte      = step.byte0;
        entry0.out_last      = (step.count == 2'd1);
        entry0.line_number   = step.line_number;
        entry0.column_number = step.column_number;
        entry1.out_byte      = step.byte1;
        entry1.out_last      = 1'b1;
        entry1.line_number   = step.line_number;
        entry1.column_number = step.column_number;
    end

    assign wr_cnt   = in_xfer ? step.count : 2'd0;
    assign n_wr_ptr = r_wr_ptr + wr_cnt;
    assign n_rd_ptr = r_rd_ptr + {1'b0, out_xfer};
    assign n_count  = r_count + {1'b0, wr_cnt} - {2'b00, out_xfer};

    always_ff @(posedge i_clk) begin
        if (wr_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= entry0;
        end
        if (wr_cnt == 2'd2) begin
            r_mem[r_wr_ptr + 2'd1] <= entry1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `CSTR_ASSERT(a_count_max, r_count <= 3'd4, "result queue overflow")
    `CSTR_ASSERT(a_ptr_gap, (r_wr_ptr - r_rd_ptr) == r_count[1:0], "queue pointers disagree with count")
    `CSTR_ASSERT_NEXT(a_drain, out_xfer && !in_xfer, r_count == $past(r_count) - 3'd1, "queue did not drain by one")

endmodule
